// ===== src/pair_keyed_chained_hash_table_defines.svh =====
`ifndef PAIR_KEYED_CHAINED_HASH_TABLE_DEFINES_SVH
`define PAIR_KEYED_CHAINED_HASH_TABLE_DEFINES_SVH

// check outside reset
`define PKHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check through reset as well
`define PKHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pkht_pkg.sv =====
package pkht_pkg;

    localparam int BUCKETS      = 256;
    localparam int POOL_ENTRIES = 256;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);

    localparam logic [BKT_W-1:0]  BKT_MASK   = BKT_W'(BUCKETS - 1);
    localparam logic [LINK_W-1:0] LINK_NULL  = '0;
    localparam logic [LINK_W-1:0] LINK_ONE   = LINK_W'(1);
    localparam logic [LINK_W-1:0] POOL_LIMIT = LINK_W'(POOL_ENTRIES);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] first_id;
        logic [31:0] second_id;
        logic        collide_in;
    } req_t;

    typedef struct packed {
        logic found;
        logic collide_out;
        logic status;
    } rsp_t;

    typedef struct packed {
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [LINK_W-1:0] next;
        logic              flag;
    } ent_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [BKT_W-1:0]  addr;
        logic [LINK_W-1:0] wdata;
    } head_cmd_t;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] addr;
        ent_t             wdata;
    } ent_cmd_t;

endpackage

// ===== src/pkht_ram.sv =====
module pkht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== src/pkht_seq.sv =====
module pkht_seq
    import pkht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp,
    output head_cmd_t         head_cmd,
    input  logic [LINK_W-1:0] head_rdata,
    output ent_cmd_t          ent_cmd,
    input  ent_t              ent_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic              op_reg;
    logic              flag_reg;
    logic [31:0]       lo_reg;
    logic [31:0]       hi_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LINK_W-1:0] head_link_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [LINK_W-1:0] used_reg;
    logic [BUCKETS-1:0] head_vld_reg;
    rsp_t              res_reg;
    rsp_t              res_next;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [31:0]       lo_in;
    logic [31:0]       hi_in;
    logic [BKT_W-1:0]  bkt_in;
    logic [LINK_W-1:0] head_link;
    logic [LINK_W-1:0] link_m1;
    logic              match;
    logic              fin;
    logic              hit;
    logic              hit_flag;
    logic              room;
    logic              alloc;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        lo_in     = (req.first_id < req.second_id) ? req.first_id : req.second_id;
        hi_in     = (req.first_id < req.second_id) ? req.second_id : req.first_id;
        bkt_in    = lo_in[BKT_W-1:0] & BKT_MASK;
        head_link = head_vld_reg[bkt_reg] ? head_rdata : LINK_NULL;
        match     = (ent_rdata.lo == lo_reg) && (ent_rdata.hi == hi_reg);
        room      = (used_reg != POOL_LIMIT);
        head_cmd  = '0;
        ent_cmd   = '0;
        fin       = 1'b0;
        hit       = 1'b0;
        hit_flag  = 1'b0;
        alloc     = 1'b0;
        link_m1   = LINK_NULL;
        res_next  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    head_cmd.en   = 1'b1;
                    head_cmd.addr = bkt_in;
                end
            end
            S_HEAD:
            begin
                if (head_link != LINK_NULL)
                begin
                    link_m1      = head_link - LINK_ONE;
                    ent_cmd.en   = 1'b1;
                    ent_cmd.addr = IDX_W'(link_m1);
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_WALK:
            begin
                if (match)
                begin
                    fin      = 1'b1;
                    hit      = 1'b1;
                    hit_flag = ent_rdata.flag;
                end
                else if (ent_rdata.next != LINK_NULL)
                begin
                    link_m1      = ent_rdata.next - LINK_ONE;
                    ent_cmd.en   = 1'b1;
                    ent_cmd.addr = IDX_W'(link_m1);
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                res_next.found       = hit;
                res_next.collide_out = hit & hit_flag;
                res_next.status      = STATUS_OK;
            end
            else if (hit)
            begin
                ent_cmd.en         = 1'b1;
                ent_cmd.we         = 1'b1;
                ent_cmd.addr       = cur_reg;
                ent_cmd.wdata      = ent_rdata;
                ent_cmd.wdata.flag = flag_reg;
                res_next.found       = 1'b1;
                res_next.collide_out = flag_reg;
                res_next.status      = STATUS_OK;
            end
            else if (room)
            begin
                alloc              = 1'b1;
                ent_cmd.en         = 1'b1;
                ent_cmd.we         = 1'b1;
                ent_cmd.addr       = IDX_W'(used_reg);
                ent_cmd.wdata.lo   = lo_reg;
                ent_cmd.wdata.hi   = hi_reg;
                ent_cmd.wdata.next = (state_reg == S_HEAD) ? head_link : head_link_reg;
                ent_cmd.wdata.flag = flag_reg;
                head_cmd.en        = 1'b1;
                head_cmd.we        = 1'b1;
                head_cmd.addr      = bkt_reg;
                head_cmd.wdata     = used_reg + LINK_ONE;
                res_next.found       = 1'b0;
                res_next.collide_out = flag_reg;
                res_next.status      = STATUS_OK;
            end
            else
            begin
                res_next.found       = 1'b0;
                res_next.collide_out = 1'b0;
                res_next.status      = STATUS_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            used_reg      <= LINK_NULL;
            head_vld_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (fin)
            begin
                res_reg <= res_next;
            end

            if (ent_cmd.en && !ent_cmd.we)
            begin
                cur_reg <= ent_cmd.addr;
            end

            if (alloc)
            begin
                used_reg              <= used_reg + LINK_ONE;
                head_vld_reg[bkt_reg] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg    <= req.operation;
                        flag_reg  <= req.collide_in;
                        lo_reg    <= lo_in;
                        hi_reg    <= hi_in;
                        bkt_reg   <= bkt_in;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    head_link_reg <= head_link;
                    state_reg     <= fin ? S_DONE : S_WALK;
                end
                S_WALK:
                begin
                    if (fin)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg       <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/pair_keyed_chained_hash_table.sv =====
// Pair-keyed rule table. Each request beat is a lookup or an add of an unordered id pair; the
// pair is ordered smaller id first, hashed to a bucket by the low bits of the smaller id, and
// the bucket chain is walked newest entry first. One response beat follows every request.
// A request reads its bucket head, then walks the chain (no entry is visited for an empty
// bucket); the walk reads the entry memory once per visited entry, and one request is in
// flight at a time. A finished response waits in an output register while the next request
// is taken. Bucket heads are empty right after reset with no clearing sweep; entries are
// never freed, and an add of a new pair when all pool entries are taken reports status 1.
module pair_keyed_chained_hash_table
    import pkht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    head_cmd_t         head_cmd;
    ent_cmd_t          ent_cmd;
    logic [LINK_W-1:0] head_rdata;
    ent_t              ent_rdata;

    pkht_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .en    (head_cmd.en),
        .we    (head_cmd.we),
        .addr  (head_cmd.addr),
        .wdata (head_cmd.wdata),
        .rdata (head_rdata)
    );

    pkht_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (POOL_ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .en    (ent_cmd.en),
        .we    (ent_cmd.we),
        .addr  (ent_cmd.addr),
        .wdata (ent_cmd.wdata),
        .rdata (ent_rdata)
    );

    pkht_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .head_cmd   (head_cmd),
        .head_rdata (head_rdata),
        .ent_cmd    (ent_cmd),
        .ent_rdata  (ent_rdata)
    );

endmodule

// ===== src/pkht_chk.sv =====
`include "pair_keyed_chained_hash_table_defines.svh"

module pkht_chk
    import pkht_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    `PKHT_ASSERT_ALWAYS(a_rsp_idle_in_reset, !rst_n |-> !rsp_valid,
        "response valid during reset")
    `PKHT_ASSERT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall,
        "second request taken while busy")
    `PKHT_ASSERT(a_full_clean,
        (rsp_valid && rsp.status == STATUS_FULL) |-> (!rsp.found && !rsp.collide_out),
        "pool-full beat carries a hit or a flag")
    `PKHT_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)),
        "stalled response beat changed")

endmodule

bind pair_keyed_chained_hash_table pkht_chk u_pkht_chk (.*);

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pkht_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          RANDOM_BEATS = 1060;

    typedef struct {
        req_t beat;
        bit   drain;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    pending_t pending_q[$];
    rsp_t     rule_answers_q[$];
    rsp_t     want_rsp;

    logic [31:0] known_a[$];
    logic [31:0] known_b[$];
    logic [7:0]  hot_bucket[4];

    int unsigned head_link [BUCKETS];
    logic [31:0] ent_lo [POOL_ENTRIES];
    logic [31:0] ent_hi [POOL_ENTRIES];
    int unsigned ent_next [POOL_ENTRIES];
    logic        ent_flag [POOL_ENTRIES];
    int unsigned ent_count;

    int unsigned beats_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    pair_keyed_chained_hash_table i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic rsp_t resolve_pair(input req_t r);
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned bkt;
        int unsigned link;
        int unsigned steps;
        int unsigned hit;
        rsp_t        res;
        lo = (r.first_id < r.second_id) ? r.first_id : r.second_id;
        hi = (r.first_id < r.second_id) ? r.second_id : r.first_id;
        bkt = int'(lo & 32'(BUCKETS - 1));
        link = head_link[bkt];
        steps = 0;
        hit = 0;
        while (link != 0 && link <= POOL_ENTRIES && steps < POOL_ENTRIES && hit == 0)
        begin
            if (ent_lo[link-1] == lo && ent_hi[link-1] == hi)
            begin
                hit = link;
            end
            else
            begin
                link = ent_next[link-1];
                steps++;
            end
        end
        res.found = (hit != 0);
        res.collide_out = 1'b0;
        res.status = STATUS_OK;
        if (r.operation == OP_LOOKUP)
        begin
            if (hit != 0)
            begin
                res.collide_out = ent_flag[hit-1];
            end
        end
        else if (hit != 0)
        begin
            ent_flag[hit-1] = r.collide_in;
            res.collide_out = r.collide_in;
        end
        else if (ent_count < POOL_ENTRIES)
        begin
            ent_lo[ent_count] = lo;
            ent_hi[ent_count] = hi;
            ent_flag[ent_count] = r.collide_in;
            ent_next[ent_count] = head_link[bkt];
            head_link[bkt] = ent_count + 1;
            ent_count++;
            res.collide_out = r.collide_in;
        end
        else
        begin
            res.status = STATUS_FULL;
        end
        return res;
    endfunction

    function automatic int unsigned draw_gap(input int unsigned beats);
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((beats % 160) < 40)
        begin
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [31:0] rand_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return 32'h0000_0000;
        end
        if (r < 10)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom();
    endfunction

    task automatic make_fresh_pair(output logic [31:0] a, output logic [31:0] b);
        int unsigned style;
        logic [7:0]  hb;
        style = $urandom_range(0, 99);
        hb = hot_bucket[$urandom_range(0, 3)];
        if (style < 40)
        begin
            a = {24'($urandom()), hb};
            b = {24'($urandom()), hb};
        end
        else if (style < 46)
        begin
            a = rand_id();
            b = a;
        end
        else
        begin
            a = rand_id();
            b = rand_id();
        end
    endtask

    task automatic push_item(input logic op, input logic [31:0] a, input logic [31:0] b,
                             input logic flag, input bit drain);
        pending_t p;
        p.beat.operation = op;
        p.beat.first_id = a;
        p.beat.second_id = b;
        p.beat.collide_in = flag;
        p.drain = drain;
        pending_q.push_back(p);
        if (op == OP_ADD)
        begin
            known_a.push_back(a);
            known_b.push_back(b);
        end
    endtask

    task automatic note_mismatch(input bit have_want, input rsp_t want, input rsp_t got);
        if (mismatches < 10)
        begin
            if (have_want)
            begin
                $display("mismatch at beat %0d: expected found=%b collide=%b status=%b, got found=%b collide=%b status=%b",
                         beats_seen, want.found, want.collide_out, want.status,
                         got.found, got.collide_out, got.status);
            end
            else
            begin
                $display("unexpected response beat %0d: found=%b collide=%b status=%b",
                         beats_seen, got.found, got.collide_out, got.status);
            end
        end
        mismatches++;
    endtask

    // present one beat at a time, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                rule_answers_q.push_back(resolve_pair(req));
                beats_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && rule_answers_q.size() != 0))
                begin
                    req <= pending_q[0].beat;
                    req_valid <= 1'b1;
                    send_gap <= draw_gap(beats_sent);
                    void'(pending_q.pop_front());
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // compare each response beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rule_answers_q.size() == 0)
                begin
                    note_mismatch(1'b0, '0, rsp);
                end
                else
                begin
                    want_rsp = rule_answers_q.pop_front();
                    if (rsp.found !== want_rsp.found ||
                        rsp.collide_out !== want_rsp.collide_out ||
                        rsp.status !== want_rsp.status)
                    begin
                        note_mismatch(1'b1, want_rsp, rsp);
                    end
                end
                beats_seen++;
            end
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                hold_left <= draw_gap(beats_seen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic        op;
        logic        fl;
        bit          fresh;
        int          n;
        int          k;
        int          new_adds;
        int          fresh_pct;
        bit          first_tail;

        #1 rst_n = 1'b0;

        for (n = 0; n < BUCKETS; n++)
        begin
            head_link[n] = 0;
        end
        ent_count = 0;
        new_adds = 0;
        first_tail = 1'b1;
        hot_bucket[0] = 8'h00;
        hot_bucket[1] = 8'hFF;
        hot_bucket[2] = 8'($urandom());
        hot_bucket[3] = 8'($urandom());

        push_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        push_item(OP_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        push_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        push_item(OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
        push_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
        push_item(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_item(OP_ADD,    32'h0000_0100, 32'h0000_0200, 1'b0, 1'b0);
        push_item(OP_LOOKUP, 32'h0000_0200, 32'h0000_0100, 1'b1, 1'b0);
        push_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        push_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0100, 1'b1, 1'b0);
        push_item(OP_ADD,    32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0);
        push_item(OP_LOOKUP, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0);
        push_item(OP_ADD,    32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0);
        push_item(OP_LOOKUP, 32'h8765_4321, 32'h1234_5678, 1'b1, 1'b0);
        push_item(OP_ADD,    32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0);
        push_item(OP_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            fresh_pct = (new_adds < POOL_ENTRIES + 40) ? 45 : 15;
            fresh = ($urandom_range(0, 99) < fresh_pct);
            fl = 1'($urandom_range(0, 1));
            if (fresh)
            begin
                make_fresh_pair(a, b);
                op = ($urandom_range(0, 99) < 75) ? OP_ADD : OP_LOOKUP;
                if (op == OP_ADD)
                begin
                    new_adds++;
                end
            end
            else
            begin
                k = $urandom_range(0, known_a.size() - 1);
                a = known_a[k];
                b = known_b[k];
                if ($urandom_range(0, 1) != 0)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                op = ($urandom_range(0, 1) != 0) ? OP_ADD : OP_LOOKUP;
            end
            push_item(op, a, b, fl, (n % 300) == 150);
        end

        // fill the pool, then keep adding new pairs
        while (new_adds < POOL_ENTRIES + 8)
        begin
            make_fresh_pair(a, b);
            fl = 1'($urandom_range(0, 1));
            push_item(OP_ADD, a, b, fl, first_tail);
            first_tail = 1'b0;
            new_adds++;
        end
        for (n = 0; n < 12; n++)
        begin
            k = $urandom_range(0, known_a.size() - 1);
            fl = 1'($urandom_range(0, 1));
            op = ($urandom_range(0, 1) != 0) ? OP_ADD : OP_LOOKUP;
            push_item(op, known_b[k], known_a[k], fl, 1'b0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid)
        begin
            @(posedge clk);
        end
        while (rule_answers_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (mismatches == 0 && rule_answers_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
